/* design/accumulator_processor_core_defines.svh */
// assertion macros shared by the core modules
// clk and rst_n are taken from the scope of the module that uses them
`ifndef ACCUMULATOR_PROCESSOR_CORE_DEFINES_SVH
`define ACCUMULATOR_PROCESSOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define APC_AST_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define APC_AST_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define APC_AST_IMP(label, ante, cons, msg)
`define APC_AST_NXT(label, ante, cons, msg)
`endif

`endif

/* design/apc_pkg.sv */
package apc_pkg;

  localparam int REQ_W  = 2;
  localparam int ADDR_W = 12;
  localparam int WORD_W = 16;
  localparam int OP_W   = 4;

  // request codes
  localparam logic [REQ_W-1:0] REQ_EXEC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  // opcodes, everything from 8 up behaves as stop
  localparam logic [OP_W-1:0] OP_LDA = 4'b0000;
  localparam logic [OP_W-1:0] OP_STO = 4'b0001;
  localparam logic [OP_W-1:0] OP_ADD = 4'b0010;
  localparam logic [OP_W-1:0] OP_SUB = 4'b0011;
  localparam logic [OP_W-1:0] OP_JMP = 4'b0100;
  localparam logic [OP_W-1:0] OP_JGE = 4'b0101;
  localparam logic [OP_W-1:0] OP_JNE = 4'b0110;
  localparam logic [OP_W-1:0] OP_STP = 4'b0111;

  typedef struct packed {
    logic fetch;     // read instruction at pc
    logic mem_load;  // write request data at request address
    logic mem_read;  // read at request address
    logic decode;    // act on fetched instruction
    logic oper;      // apply operand to accumulator
    logic out_load;  // capture result registers
    logic out_rd;    // result carries the read word
  } apc_cmd_t;

  typedef struct packed {
    logic stopped;
    logic need_operand;
  } apc_stat_t;

endpackage

/* design/apc_if.sv */
interface apc_in_if;
  logic                            valid;
  logic                            ready;
  logic [apc_pkg::REQ_W-1:0]       req_type;
  logic [apc_pkg::ADDR_W-1:0]      address;
  logic [apc_pkg::WORD_W-1:0]      write_data;

  modport source (output valid, output req_type, output address, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input address, input write_data,
                output ready);
endinterface

interface apc_out_if;
  logic                            valid;
  logic                            ready;
  logic [apc_pkg::ADDR_W-1:0]      pc_out;
  logic signed [apc_pkg::WORD_W-1:0] acc_out;
  logic                            halted;
  logic [apc_pkg::WORD_W-1:0]      read_data;

  modport source (output valid, output pc_out, output acc_out, output halted,
                  output read_data, input ready);
  modport sink (input valid, input pc_out, input acc_out, input halted,
                input read_data, output ready);
endinterface

/* design/apc_datapath.sv */
`include "accumulator_processor_core_defines.svh"

module apc_datapath #(
  parameter int MEM_WORDS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  apc_pkg::apc_cmd_t            cmd,
  output apc_pkg::apc_stat_t           stat,
  input  logic [apc_pkg::ADDR_W-1:0]   in_address,
  input  logic [apc_pkg::WORD_W-1:0]   in_write_data,
  output logic [apc_pkg::ADDR_W-1:0]   out_pc,
  output logic [apc_pkg::WORD_W-1:0]   out_acc,
  output logic                         out_halted,
  output logic [apc_pkg::WORD_W-1:0]   out_read_data
);

  localparam int AW = $clog2(MEM_WORDS);
  // depth is at least 16, so the quotient of a 12-bit address has this many bits
  localparam int MOD_STEPS = apc_pkg::ADDR_W - 4;

  // address modulo depth by restoring compare and subtract
  function automatic logic [AW-1:0] mem_index(input logic [apc_pkg::ADDR_W-1:0] a);
    logic [apc_pkg::ADDR_W-1:0] x;
    x = a;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (32'(x) >= (MEM_WORDS << k)) begin
        x = x - apc_pkg::ADDR_W'(MEM_WORDS << k);
      end
    end
    return x[AW-1:0];
  endfunction

  logic [apc_pkg::WORD_W-1:0] mem_r [MEM_WORDS];
  logic [apc_pkg::WORD_W-1:0] mem_q_r;

  logic [apc_pkg::ADDR_W-1:0] pc_r;
  logic [apc_pkg::WORD_W-1:0] acc_r;
  logic                       stop_r;
  logic [apc_pkg::OP_W-1:0]   op_r;

  logic [apc_pkg::ADDR_W-1:0] pc_out_r;
  logic [apc_pkg::WORD_W-1:0] acc_out_r;
  logic                       halted_r;
  logic [apc_pkg::WORD_W-1:0] read_data_r;

  logic [apc_pkg::OP_W-1:0]   opc;
  logic [apc_pkg::ADDR_W-1:0] s_addr;
  logic [apc_pkg::ADDR_W-1:0] pc_inc;
  logic                       need_operand;

  logic                       mem_we;
  logic                       mem_re;
  logic [apc_pkg::ADDR_W-1:0] addr_raw;
  logic [AW-1:0]              mem_addr;
  logic [apc_pkg::WORD_W-1:0] mem_wdata;

  assign opc    = mem_q_r[apc_pkg::WORD_W-1 -: apc_pkg::OP_W];
  assign s_addr = mem_q_r[apc_pkg::ADDR_W-1:0];
  assign pc_inc = pc_r + 1'b1;
  assign need_operand = (opc == apc_pkg::OP_LDA) || (opc == apc_pkg::OP_ADD) ||
                        (opc == apc_pkg::OP_SUB);

  assign stat.stopped      = stop_r;
  assign stat.need_operand = need_operand;

  // single memory port, one user per cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    addr_raw  = pc_r;
    mem_wdata = in_write_data;
    if (cmd.fetch) begin
      mem_re = 1'b1;
    end else if (cmd.mem_read) begin
      mem_re   = 1'b1;
      addr_raw = in_address;
    end else if (cmd.mem_load) begin
      mem_we   = 1'b1;
      addr_raw = in_address;
    end else if (cmd.decode) begin
      addr_raw  = s_addr;
      mem_re    = need_operand;
      mem_we    = (opc == apc_pkg::OP_STO);
      mem_wdata = acc_r;
    end
  end

  assign mem_addr = mem_index(addr_raw);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem_r[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      acc_r  <= '0;
      stop_r <= 1'b0;
    end else begin
      if (cmd.decode) begin
        case (opc)
          apc_pkg::OP_LDA, apc_pkg::OP_STO, apc_pkg::OP_ADD, apc_pkg::OP_SUB: begin
            pc_r <= pc_inc;
          end
          apc_pkg::OP_JMP: begin
            pc_r <= s_addr;
          end
          apc_pkg::OP_JGE: begin
            pc_r <= acc_r[apc_pkg::WORD_W-1] ? pc_inc : s_addr;
          end
          apc_pkg::OP_JNE: begin
            pc_r <= (acc_r != '0) ? s_addr : pc_inc;
          end
          default: begin
            stop_r <= 1'b1;
          end
        endcase
      end
      if (cmd.oper) begin
        case (op_r)
          apc_pkg::OP_LDA: acc_r <= mem_q_r;
          apc_pkg::OP_ADD: acc_r <= acc_r + mem_q_r;
          apc_pkg::OP_SUB: acc_r <= acc_r - mem_q_r;
          default:         acc_r <= acc_r;
        endcase
      end
    end
  end

  // opcode kept while the operand read overwrites mem_q_r
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      op_r <= opc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pc_out_r    <= pc_r;
      acc_out_r   <= acc_r;
      halted_r    <= stop_r;
      read_data_r <= cmd.out_rd ? mem_q_r : '0;
    end
  end

  assign out_pc        = pc_out_r;
  assign out_acc       = acc_out_r;
  assign out_halted    = halted_r;
  assign out_read_data = read_data_r;

  `APC_AST_NXT(a_stop_sticky, stop_r, stop_r, "stop flag cleared without reset")
  `APC_AST_IMP(a_no_decode_stopped, cmd.decode, !stop_r, "instruction decoded while stopped")
  `APC_AST_IMP(a_port_single, mem_we, !mem_re, "memory read and write in one cycle")

endmodule

/* design/apc_ctrl.sv */
`include "accumulator_processor_core_defines.svh"

module apc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [apc_pkg::REQ_W-1:0]  in_req_type,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  apc_pkg::apc_stat_t         stat,
  output apc_pkg::apc_cmd_t          cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_OPER = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       rd_flag_r;
  logic       in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_FIN;
          case (in_req_type)
            apc_pkg::REQ_EXEC: begin
              if (!stat.stopped) begin
                cmd.fetch = 1'b1;
                state_nxt = S_DEC;
              end
            end
            apc_pkg::REQ_LOAD: cmd.mem_load = 1'b1;
            apc_pkg::REQ_READ: cmd.mem_read = 1'b1;
            default:           state_nxt = S_FIN;
          endcase
        end
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        state_nxt  = stat.need_operand ? S_OPER : S_FIN;
      end
      S_OPER: begin
        cmd.oper  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          cmd.out_rd    = rd_flag_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_flag_r <= (in_req_type == apc_pkg::REQ_READ);
    end
  end

  `APC_AST_NXT(a_fin_done, cmd.out_load, out_valid_r && (state_r == S_IDLE), "result not posted")
  `APC_AST_NXT(a_stop_skip, in_fire && stat.stopped, state_r == S_FIN, "fetch while stopped")
  `APC_AST_IMP(a_oper_seq, state_r == S_OPER, $past(state_r) == S_DEC, "operand without decode")

endmodule

/* design/accumulator_processor_core.sv */
// 16-bit accumulator processor with a single-port synchronous memory of MEM_WORDS words.
// Each request on in_ch produces exactly one result on out_ch with pc, accumulator and
// stop flag after the request, plus the memory word for read requests (zero otherwise).
// Load, read, stopped execute and unused request codes go straight to the result step;
// STO, jumps and stop add a decode step; LDA, ADD and SUB add decode and operand steps.
// The one memory port serves the instruction fetch and then the operand access, each a
// registered read, before the result register is posted. A finished result waits in
// that register while the next request is accepted. Memory needs no clearing pass:
// words must be loaded before they are read. Addresses wrap modulo MEM_WORDS.

module accumulator_processor_core #(
  parameter int MEM_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  apc_in_if.sink      in_ch,
  apc_out_if.source   out_ch
);

  // command and status between sequencer and datapath
  apc_pkg::apc_cmd_t  cmd;
  apc_pkg::apc_stat_t stat;

  logic [apc_pkg::WORD_W-1:0] acc_word;

  // sequencer: request transfer, fetch/decode/operand steps, result transfer
  apc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // datapath: memory, pc, accumulator, stop flag and result registers
  apc_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_address    (in_ch.address),
    .in_write_data (in_ch.write_data),
    .out_pc        (out_ch.pc_out),
    .out_acc       (acc_word),
    .out_halted    (out_ch.halted),
    .out_read_data (out_ch.read_data)
  );

  // accumulator is reported as two's complement
  assign out_ch.acc_out = $signed(acc_word);

endmodule

/* tb/testbench.sv */
module testbench;
  import apc_pkg::*;

  localparam int          MEM_DEPTH    = 4096;
  localparam int          ITEM_COUNT   = 1200;   // stop generating random requests here
  localparam int unsigned PHASE_LEN    = 150;    // requests per idling phase
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 12;     // a few times the slowest request
  localparam int          MAX_PRINTS   = 40;

  // request code 3 is not decoded by the core, it only reports state
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  // the two copies of the machine: one plans the stimulus, one checks results
  localparam int PLAN  = 0;
  localparam int CHECK = 1;

  localparam logic [ADDR_W-1:0] CODE_BASE = 12'h000;
  localparam logic [ADDR_W-1:0] DATA_BASE = 12'hF00;

  // idling per phase: none, sender, receiver, both lightly
  localparam int unsigned SEND_IDLE[4]  = '{0, 57, 0, 10};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 57, 10};

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } cpu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic [WORD_W-1:0] acc;
    logic              halted;
    logic [WORD_W-1:0] rd;
  } cpu_view_t;

  typedef struct {
    cpu_req_t    rq;
    int unsigned gap;     // idle cycles before this request is offered
    bit          drain;   // hold off until every result so far has arrived
  } tb_item_t;

  logic clk;
  logic rst_n;

  apc_in_if  in_ch ();
  apc_out_if out_ch ();

  accumulator_processor_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // machine state, one copy per user
  logic [WORD_W-1:0] mem_img [2][MEM_DEPTH];
  bit                written [2][MEM_DEPTH];
  logic [ADDR_W-1:0] pc_m    [2];
  logic [WORD_W-1:0] acc_m   [2];
  bit                halt_m  [2];
  logic [ADDR_W-1:0] known_addr[$];   // addresses the planner may read back

  tb_item_t    request_q[$];     // requests waiting to be offered
  cpu_view_t   predicted_q[$];   // machine state expected from each transfer
  tb_item_t    cur;
  bit          have_item;
  int unsigned gap_left;
  logic        in_fire;
  int unsigned checked_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned hold_left;
  int unsigned next_hold_at;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(string msg);
    if (err_cnt < MAX_PRINTS) $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // memory write that keeps track of which words hold defined data
  function automatic void store_word(int who, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] d);
    mem_img[who][a] = d;
    if (!written[who][a]) begin
      written[who][a] = 1'b1;
      if (who == PLAN) known_addr.push_back(a);
    end
  endfunction

  // one request applied to one copy of the machine, returns the state after it
  function automatic cpu_view_t step_machine(int who, cpu_req_t rq);
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] rd;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] pc_new;
    cpu_view_t         v;
    rd = '0;
    case (rq.req)
      REQ_EXEC: begin
        // a stopped machine ignores execute requests entirely
        if (!halt_m[who]) begin
          word   = mem_img[who][pc_m[who]];
          op     = word[WORD_W-1 -: OP_W];
          s      = word[ADDR_W-1:0];
          pc_new = pc_m[who] + 1'b1;   // wraps at 12 bits
          case (op)
            OP_LDA: acc_m[who] = mem_img[who][s];
            OP_STO: store_word(who, s, acc_m[who]);
            OP_ADD: acc_m[who] = acc_m[who] + mem_img[who][s];
            OP_SUB: acc_m[who] = acc_m[who] - mem_img[who][s];
            OP_JMP: pc_new = s;
            OP_JGE: if (!acc_m[who][WORD_W-1]) pc_new = s;   // signed test
            OP_JNE: if (acc_m[who] != '0) pc_new = s;
            default: begin
              // stop and every unused opcode: pc and acc stay put
              halt_m[who] = 1'b1;
              pc_new      = pc_m[who];
            end
          endcase
          pc_m[who] = pc_new;
        end
      end
      REQ_LOAD: store_word(who, rq.addr, rq.data);
      REQ_READ: rd = mem_img[who][rq.addr];
      default: ;
    endcase
    v.pc     = pc_m[who];
    v.acc    = acc_m[who];
    v.halted = halt_m[who];
    v.rd     = rd;
    return v;
  endfunction

  // operand data, leaning on zero and the sign and overflow boundaries
  function automatic logic [WORD_W-1:0] gen_data();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return 16'h8000;
    if (r == 3) return 16'hFFFF;
    return WORD_W'($urandom);
  endfunction

  // a non-stopping instruction; jumps mostly stay in the code window or nearby
  function automatic logic [WORD_W-1:0] gen_instr(logic [ADDR_W-1:0] here);
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] s;
    int unsigned       r;
    op = OP_W'($urandom_range(OP_JNE));
    r  = $urandom_range(9);
    if (op inside {OP_JMP, OP_JGE, OP_JNE})
      s = (r < 5) ? CODE_BASE + ADDR_W'($urandom_range(63)) :
          (r < 8) ? here + ADDR_W'(1 + $urandom_range(7)) : ADDR_W'($urandom);
    else
      s = (r < 7) ? DATA_BASE + ADDR_W'($urandom_range(31)) : ADDR_W'($urandom);
    return {op, s};
  endfunction

  // queue one request; the planning copy advances so later choices know the state
  function automatic void push_req(logic [REQ_W-1:0] req, logic [ADDR_W-1:0] a,
                                   logic [WORD_W-1:0] d);
    tb_item_t    it;
    int unsigned pct;
    it.rq.req  = req;
    it.rq.addr = a;
    it.rq.data = d;
    pct        = SEND_IDLE[(request_q.size() / PHASE_LEN) % 4];
    it.gap     = 0;
    while (it.gap < 20 && $urandom_range(99) < pct) it.gap++;
    it.drain   = (request_q.size() % 97 == 96);
    void'(step_machine(PLAN, it.rq));
    request_q.push_back(it);
  endfunction

  // execute one instruction, first loading code at pc and its operand if needed
  function automatic void plan_exec();
    logic [WORD_W-1:0] word;
    logic [ADDR_W-1:0] pc;
    pc = pc_m[PLAN];
    if (!halt_m[PLAN]) begin
      word = mem_img[PLAN][pc];
      // unwritten, stopping, or now and then patched over to vary the flow
      if (!written[PLAN][pc] || word[WORD_W-1 -: OP_W] > OP_JNE ||
          $urandom_range(19) == 0) begin
        word = gen_instr(pc);
        push_req(REQ_LOAD, pc, word);
      end
      if (word[WORD_W-1 -: OP_W] inside {OP_LDA, OP_ADD, OP_SUB} &&
          !written[PLAN][word[ADDR_W-1:0]])
        push_req(REQ_LOAD, word[ADDR_W-1:0], gen_data());
    end
    push_req(REQ_EXEC, ADDR_W'($urandom), WORD_W'($urandom));
  endfunction

  // driver: offers requests at the falling edge, one nonblocking write of valid per edge
  always @(negedge clk) begin
    bit nv;
    nv = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && !in_fire) begin
        nv = 1'b1;   // not taken yet, keep offering
      end else begin
        if (!have_item && request_q.size() != 0) begin
          cur       = request_q.pop_front();
          have_item = 1'b1;
          gap_left  = cur.gap;
        end
        if (have_item) begin
          if (gap_left != 0) begin
            gap_left--;
          end else if (!(cur.drain && predicted_q.size() != 0)) begin
            in_ch.req_type   <= cur.rq.req;
            in_ch.address    <= cur.rq.addr;
            in_ch.write_data <= cur.rq.data;
            nv        = 1'b1;
            have_item = 1'b0;
          end
        end
      end
    end
    in_ch.valid <= nv;
  end

  // long receiver hold-off, counted here so the sender keeps pushing meanwhile
  always @(negedge clk) begin
    if (!rst_n) begin
      hold_left    <= 0;
      next_hold_at <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (checked_cnt >= next_hold_at) begin
      hold_left    <= 150;
      next_hold_at <= next_hold_at + 600;
    end
  end

  // receiver: random stalls by phase
  always @(negedge clk) begin
    if (!rst_n)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= (hold_left == 0) &&
                      ($urandom_range(99) >= RECV_STALL[(checked_cnt / PHASE_LEN) % 4]);
  end

  // monitor: predict on each request transfer, compare on each result transfer
  always @(posedge clk) begin
    cpu_view_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        cpu_req_t rq;
        rq.req  = in_ch.req_type;
        rq.addr = in_ch.address;
        rq.data = in_ch.write_data;
        predicted_q.push_back(step_machine(CHECK, rq));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_q.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing outstanding", checked_cnt));
        end else begin
          want = predicted_q.pop_front();
          if (out_ch.pc_out !== want.pc)
            report_error($sformatf("result %0d pc_out %h, expected %h",
                                   checked_cnt, out_ch.pc_out, want.pc));
          if (out_ch.acc_out !== want.acc)
            report_error($sformatf("result %0d acc_out %h, expected %h",
                                   checked_cnt, out_ch.acc_out, want.acc));
          if (out_ch.halted !== want.halted)
            report_error($sformatf("result %0d halted %b, expected %b",
                                   checked_cnt, out_ch.halted, want.halted));
          if (out_ch.read_data !== want.rd)
            report_error($sformatf("result %0d read_data %h, expected %h",
                                   checked_cnt, out_ch.read_data, want.rd));
        end
        checked_cnt++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("accumulator_processor_core test failed");
      $finish;
    end
  end

  initial begin
    int unsigned       r;
    logic [ADDR_W-1:0] a;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_EXEC;
    in_ch.address    = '0;
    in_ch.write_data = '0;
    out_ch.ready     = 1'b0;
    have_item        = 1'b0;
    gap_left         = 0;
    checked_cnt      = 0;
    err_cnt          = 0;
    cycle_cnt        = 0;
    for (int m = 0; m < 2; m++) begin
      pc_m[m]   = '0;
      acc_m[m]  = '0;
      halt_m[m] = 1'b0;
    end

    // directed: overflow on add, signed jge not taken, jmp to the last word,
    // pc wrap to zero, zero acc for jne not taken and jge taken, store and read back
    push_req(REQ_LOAD, 12'h000, {OP_LDA, 12'h800});
    push_req(REQ_LOAD, 12'h800, 16'h7FFF);
    push_req(REQ_LOAD, 12'h001, {OP_ADD, 12'h801});
    push_req(REQ_LOAD, 12'h801, 16'h0001);
    push_req(REQ_LOAD, 12'h002, {OP_JGE, 12'h010});
    push_req(REQ_LOAD, 12'h003, {OP_JMP, 12'hFFF});
    push_req(REQ_LOAD, 12'hFFF, {OP_SUB, 12'h800});
    repeat (5) push_req(REQ_EXEC, 12'hFFF, 16'hFFFF);   // ends back at pc 0, acc 1
    push_req(REQ_LOAD, 12'h000, {OP_SUB, 12'h801});
    push_req(REQ_EXEC, '0, '0);                          // acc 0
    push_req(REQ_LOAD, 12'h001, {OP_JNE, 12'h005});
    push_req(REQ_EXEC, '0, '0);                          // falls through
    push_req(REQ_LOAD, 12'h002, {OP_JGE, 12'h005});
    push_req(REQ_EXEC, '0, '0);                          // taken on zero
    push_req(REQ_LOAD, 12'h005, {OP_STO, 12'h803});
    push_req(REQ_EXEC, '0, '0);
    push_req(REQ_READ, 12'h803, 16'hFFFF);
    push_req(REQ_READ, 12'hFFF, '0);
    push_req(REQ_NONE, 12'hFFF, 16'hFFFF);

    // random: mostly execution of generated code, with loads, reads and noise
    while (request_q.size() < ITEM_COUNT) begin
      r = $urandom_range(99);
      if (r < 60) begin
        plan_exec();
      end else if (r < 68) begin
        a = CODE_BASE + ADDR_W'($urandom_range(63));
        push_req(REQ_LOAD, a, gen_instr(a));
      end else if (r < 78) begin
        push_req(REQ_LOAD, ADDR_W'($urandom), gen_data());
      end else if (r < 92) begin
        push_req(REQ_READ, known_addr[$urandom_range(known_addr.size() - 1)],
                 WORD_W'($urandom));
      end else begin
        push_req(REQ_NONE, ADDR_W'($urandom), WORD_W'($urandom));
      end
    end

    // closing: stop via STP or an unused opcode, then show that only loads
    // and reads still act
    push_req(REQ_LOAD, pc_m[PLAN], {OP_W'(OP_STP + $urandom_range(8)), ADDR_W'($urandom)});
    repeat (4) push_req(REQ_EXEC, ADDR_W'($urandom), WORD_W'($urandom));
    push_req(REQ_LOAD, ADDR_W'($urandom), gen_data());
    push_req(REQ_READ, known_addr[$urandom_range(known_addr.size() - 1)], '0);
    push_req(REQ_NONE, ADDR_W'($urandom), WORD_W'($urandom));
    push_req(REQ_EXEC, '0, '0);

    // synchronous reset, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || have_item || in_ch.valid || predicted_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0)
      $display("accumulator_processor_core test passed");
    else
      $display("accumulator_processor_core test failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/apc_pkg.sv
design/apc_if.sv
design/apc_datapath.sv
design/apc_ctrl.sv
design/accumulator_processor_core.sv
tb/testbench.sv
